/* hw/rtl/dasl_pkg.sv */
// Shared types, codes and sizes for the dual-axis sorted list.
// No dependencies; imported by every other file of the block.
package dasl_pkg;

	localparam int DASL_DEPTH = 16;
	localparam int KEY_W      = 16;
	localparam int HANDLE_W   = 8;
	localparam int STATUS_W   = 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [HANDLE_W-1:0]     handle;
	} entry_t;

	// per-cell compare results against the request
	typedef struct packed {
		logic ge;   // occupied and key >= request key
		logic gt;   // occupied and key >  request key
		logic hit;  // occupied and handle matches
	} flags_t;

	// per-cell move command for the update cycle
	typedef struct packed {
		logic load_new;
		logic take_left;
		logic take_right;
	} move_t;

endpackage

/* hw/rtl/dual_axis_sorted_list.sv */
// Top level of the dual-axis sorted list: request capture, sequencer,
// two cell chains (x and y) and the result register. Uses dasl_pkg, dasl_chain.
//
//  channel | direction | handshake           | payload
//  request | in        | in_valid / in_stall | kind, handle, x_key, y_key
//  result  | out       | out_valid/out_stall | status, x_position, y_position, entry_count
//
// Each request goes through accept, compare in every cell (flags
// registered), then shift the cells and load the result register.
// One request is in work at a time; the next is accepted while a result waits.
// The update cycle holds while the result register is full and stalled.
// Reset clears the entry count and control; list contents stay undefined.
module dual_axis_sorted_list import dasl_pkg::*; #(
	parameter int DEPTH = DASL_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [HANDLE_W-1:0]        handle,
	input  logic signed [KEY_W-1:0]    x_key,
	input  logic signed [KEY_W-1:0]    y_key,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [CNT_W-1:0]           x_position,
	output logic [CNT_W-1:0]           y_position,
	output logic [CNT_W-1:0]           entry_count
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVAL  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t                  state_q;
	logic                    kind_q;
	logic [HANDLE_W-1:0]     handle_q;
	logic signed [KEY_W-1:0] xkey_q, ykey_q;
	logic [CNT_W-1:0]        count_q;
	logic                    res_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [CNT_W-1:0]        xpos_q, ypos_q, ecount_q;

	logic             accept, go, full, change;
	logic [CNT_W-1:0] x_pos, y_pos, count_next;
	logic             x_hit;
	entry_t           x_req, y_req;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign go       = (state_q == ST_APPLY) && (!res_valid_q || !out_stall);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign change   = (kind_q == KIND_INSERT) ? !full : x_hit;

	assign x_req = '{key: xkey_q, handle: handle_q};
	assign y_req = '{key: ykey_q, handle: handle_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_EVAL;
				ST_EVAL:  state_q <= ST_APPLY;
				ST_APPLY: if (go) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			handle_q <= handle;
			xkey_q   <= x_key;
			ykey_q   <= y_key;
		end
	end

	dasl_chain #(.DEPTH(DEPTH)) u_x_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.eval     (state_q == ST_EVAL),
		.apply    (go && change),
		.kind     (kind_q),
		.req      (x_req),
		.count    (count_q),
		.position (x_pos),
		.hit      (x_hit)
	);

	// y hit is implied by x hit for any reachable sequence of requests
	dasl_chain #(.DEPTH(DEPTH)) u_y_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.eval     (state_q == ST_EVAL),
		.apply    (go && change),
		.kind     (kind_q),
		.req      (y_req),
		.count    (count_q),
		.position (y_pos),
		.hit      ()
	);

	always_comb begin
		count_next = count_q;
		if (change) begin
			count_next = (kind_q == KIND_INSERT) ? count_q + CNT_W'(1) :
				count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (go) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ecount_q <= count_next;
			if (!change) begin
				status_q <= (kind_q == KIND_INSERT) ? STATUS_FULL : STATUS_NOTFOUND;
				xpos_q   <= '0;
				ypos_q   <= '0;
			end else begin
				status_q <= STATUS_DONE;
				xpos_q   <= x_pos;
				ypos_q   <= y_pos;
			end
		end
	end

	assign out_valid   = res_valid_q;
	assign status      = status_q;
	assign x_position  = xpos_q;
	assign y_position  = ypos_q;
	assign entry_count = ecount_q;

endmodule

/* hw/rtl/dasl_cell.sv */
// One list cell: holds a key/handle entry, registers its compare flags,
// and moves data from either neighbor or the request. Uses dasl_pkg.
module dasl_cell import dasl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   eval,
	input  logic   occupied,
	input  entry_t req,
	input  move_t  move,
	input  entry_t left_data,
	input  entry_t right_data,
	output entry_t data,
	output flags_t flags
);

	entry_t entry_q;
	flags_t flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (eval) begin
			flags_q.ge  <= occupied && (entry_q.key >= req.key);
			flags_q.gt  <= occupied && (entry_q.key > req.key);
			flags_q.hit <= occupied && (entry_q.handle == req.handle);
		end
	end

	always_ff @(posedge clk) begin
		if (move.load_new) begin
			entry_q <= req;
		end else if (move.take_left) begin
			entry_q <= left_data;
		end else if (move.take_right) begin
			entry_q <= right_data;
		end
	end

	assign data  = entry_q;
	assign flags = flags_q;

endmodule

/* hw/rtl/dasl_chain.sv */
// Row of DEPTH cells forming one sorted list, with the move control and
// the position encoder. Uses dasl_pkg and dasl_cell.
module dasl_chain import dasl_pkg::*; #(
	parameter int DEPTH = DASL_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             eval,
	input  logic             apply,
	input  logic             kind,
	input  entry_t           req,
	input  logic [CNT_W-1:0] count,
	output logic [CNT_W-1:0] position,
	output logic             hit
);

	entry_t            data [DEPTH];
	flags_t            flags [DEPTH];
	move_t             move [DEPTH];
	logic [DEPTH-1:0]  ge, gt, m, rm, first_ge, first_hit;
	logic              append;
	logic [IDX_W-1:0]  enc_ge, enc_hit;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge[i] = flags[i].ge;
			gt[i] = flags[i].gt;
			m[i]  = flags[i].hit;
		end
		append = ~|gt;
		// ge is a thermometer over a sorted list; hits need a prefix OR
		rm[0]        = m[0];
		first_ge[0]  = ge[0];
		first_hit[0] = m[0];
		for (int i = 1; i < DEPTH; i++) begin
			rm[i]        = rm[i-1] | m[i];
			first_ge[i]  = ge[i] & ~ge[i-1];
			first_hit[i] = m[i] & ~rm[i-1];
		end
		enc_ge  = '0;
		enc_hit = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_ge[i]) enc_ge = enc_ge | IDX_W'(i);
			if (first_hit[i]) enc_hit = enc_hit | IDX_W'(i);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			move[i].load_new = apply && (kind == KIND_INSERT) &&
				(append ? (CNT_W'(i) == count) : first_ge[i]);
			move[i].take_left = apply && (kind == KIND_INSERT) && !append &&
				(i > 0) && ge[(i > 0) ? i - 1 : 0];
			move[i].take_right = apply && (kind == KIND_DELETE) && rm[i] &&
				(i < DEPTH - 1);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dasl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.eval       (eval),
			.occupied   (CNT_W'(g) < count),
			.req        (req),
			.move       (move[g]),
			.left_data  (data[(g > 0) ? g - 1 : g]),
			.right_data (data[(g < DEPTH - 1) ? g + 1 : g]),
			.data       (data[g]),
			.flags      (flags[g])
		);
	end

	assign hit = rm[DEPTH-1];

	always_comb begin
		if (kind == KIND_INSERT) begin
			position = append ? count : CNT_W'(enc_ge);
		end else begin
			position = CNT_W'(enc_hit);
		end
	end

endmodule

/* hw/rtl/dasl_checker.sv */
// Port-level checks for dual_axis_sorted_list, attached by bind.
// Uses dasl_pkg for the status codes and the default depth.
module dasl_checker import dasl_pkg::*; #(
	parameter int DEPTH = DASL_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [CNT_W-1:0]    x_position,
	input logic [CNT_W-1:0]    y_position,
	input logic [CNT_W-1:0]    entry_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
			$stable(x_position) && $stable(entry_count))
		else $error("stalled result changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |->
			entry_count == CNT_W'(DEPTH) && x_position == '0 && y_position == '0)
		else $error("dropped insert with bad fields");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_DONE |->
			x_position <= entry_count && y_position <= entry_count)
		else $error("position beyond entry count");

endmodule

bind dual_axis_sorted_list dasl_checker #(.DEPTH(DEPTH)) u_dasl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.x_position  (x_position),
	.y_position  (y_position),
	.entry_count (entry_count)
);
